// ===== rtl/rcsa_pkg.sv =====
package rcsa_pkg;

  // Row buffer geometry
  localparam int ROW_WIDTH    = 64;
  localparam int ADDR_W       = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;

  // Field widths
  localparam int COORD_W      = 16;
  localparam int LEN_W        = 7;
  localparam int ALPHA_W      = 8;
  // x - row_left needs 17 bits, adding a run offset up to 127 needs one more
  localparam int IDX_W        = COORD_W + 2;

  localparam int SPAN_MAX_LEN = 64;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

  // Commands
  localparam logic CMD_ACC   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW  = 1'd1;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_ADD_SAT,
    ALU_CMP
  } alu_op_e;

  // Row buffer access request
  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ALPHA_W-1:0] wr_data;
    logic               clr;
  } buf_req_t;

endpackage

// ===== rtl/row_coverage_span_accumulator_core.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// input    | in_valid_i / in_ready_o    | command_i pixel_x_i pixel_y_i run_len_i coverage_i
// span     | span_valid_o / span_ready_i| span_x_o span_y_o span_len_o span_alpha_o last_o
// config   | cfg_we_i (no wait)         | cfg_idx_i cfg_wdata_i
//
// An accumulate item with no row change keeps in_ready_o low while it walks its run: a pixel
// outside the buffer is skipped, one inside it is read, then saturating-added and written back.
// A row change, or a flush of an open row, first scans the buffer one cell per cycle while
// no finished span waits for the output slot; a span waiting for the slot stalls the scan.
// in_ready_o is high only while the sequencer is idle; the span output register keeps
// the last span on offer while the next item is taken. Reset clears the valid bits at once.
module row_coverage_span_accumulator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [rcsa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rcsa_pkg::COORD_W-1:0]         cfg_wdata_i,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic signed [rcsa_pkg::COORD_W-1:0]  pixel_x_i,
  input  logic signed [rcsa_pkg::COORD_W-1:0]  pixel_y_i,
  input  logic [rcsa_pkg::LEN_W-1:0]           run_len_i,
  input  logic [rcsa_pkg::ALPHA_W-1:0]         coverage_i,
  // spans
  output logic                                 span_valid_o,
  input  logic                                 span_ready_i,
  output logic signed [rcsa_pkg::COORD_W-1:0]  span_x_o,
  output logic signed [rcsa_pkg::COORD_W-1:0]  span_y_o,
  output logic [rcsa_pkg::LEN_W-1:0]           span_len_o,
  output logic [rcsa_pkg::ALPHA_W-1:0]         span_alpha_o,
  output logic                                 last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_SCAN_EV,
    ST_SCAN_END,
    ST_SCAN_LAST
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [rcsa_pkg::COORD_W-1:0] row_left_q, row_left_d;
  logic signed [rcsa_pkg::COORD_W-1:0] top_row_q, top_row_d;

  // open row
  logic signed [rcsa_pkg::COORD_W-1:0] open_row_q, open_row_d;
  logic                                row_open_q, row_open_d;

  // item in progress
  logic                                cmd_q, cmd_d;
  logic signed [rcsa_pkg::COORD_W-1:0] y_q, y_d;
  logic [rcsa_pkg::ALPHA_W-1:0]        cov_q, cov_d;
  logic [rcsa_pkg::LEN_W-1:0]          rem_q, rem_d;
  logic signed [rcsa_pkg::IDX_W-1:0]   idx_q, idx_d;

  // scan: span being grown and one closed span waiting for its last flag
  logic [rcsa_pkg::ADDR_W-1:0]         ptr_q, ptr_d;
  logic [rcsa_pkg::LEN_W-1:0]          cur_len_q, cur_len_d;
  logic [rcsa_pkg::ALPHA_W-1:0]        cur_alpha_q, cur_alpha_d;
  logic [rcsa_pkg::ADDR_W-1:0]         cur_start_q, cur_start_d;
  logic                                pend_vld_q, pend_vld_d;
  logic [rcsa_pkg::LEN_W-1:0]          pend_len_q, pend_len_d;
  logic [rcsa_pkg::ALPHA_W-1:0]        pend_alpha_q, pend_alpha_d;
  logic [rcsa_pkg::ADDR_W-1:0]         pend_start_q, pend_start_d;

  // span output register
  logic                                out_vld_q, out_vld_d;
  logic signed [rcsa_pkg::COORD_W-1:0] span_x_q, span_x_d;
  logic signed [rcsa_pkg::COORD_W-1:0] span_y_q, span_y_d;
  logic [rcsa_pkg::LEN_W-1:0]          span_len_q, span_len_d;
  logic [rcsa_pkg::ALPHA_W-1:0]        span_alpha_q, span_alpha_d;
  logic                                last_q, last_d;

  rcsa_pkg::buf_req_t                  buf_req;
  logic [rcsa_pkg::ALPHA_W-1:0]        rd_data;
  rcsa_pkg::alu_op_e                   alu_op;
  logic [rcsa_pkg::ALPHA_W-1:0]        alu_b;
  logic [rcsa_pkg::ALPHA_W-1:0]        alu_res;
  logic                                alu_eq;

  logic                                out_free;
  logic                                in_range;
  logic                                extend;
  logic                                closing;
  logic                                stall;
  logic                                finish;
  logic                                push;
  logic                                push_last;

  rcsa_row_buf u_row_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (buf_req),
    .rd_data_o (rd_data)
  );

  // One unit serves both loops: add coverage in ST_ACC_WR, compare cell to span elsewhere.
  assign alu_op = (state_q == ST_ACC_WR) ? rcsa_pkg::ALU_ADD_SAT : rcsa_pkg::ALU_CMP;
  assign alu_b  = (state_q == ST_ACC_WR) ? cov_q : cur_alpha_q;

  rcsa_alu u_alu (
    .op_i  (alu_op),
    .a_i   (rd_data),
    .b_i   (alu_b),
    .res_o (alu_res),
    .eq_o  (alu_eq)
  );

  // The output slot can take a span when empty or when its span leaves this cycle.
  assign out_free = !out_vld_q || span_ready_i;

  assign in_range = !idx_q[rcsa_pkg::IDX_W-1] &&
                    (idx_q[rcsa_pkg::IDX_W-2:0] < (rcsa_pkg::IDX_W-1)'(rcsa_pkg::ROW_WIDTH));

  // Span growth on the cell under evaluation
  assign extend  = (cur_len_q != '0) && alu_eq &&
                   (cur_len_q != rcsa_pkg::LEN_W'(rcsa_pkg::SPAN_MAX_LEN));
  assign closing = (cur_len_q != '0) && !extend;

  always_comb begin
    state_d      = state_q;
    row_left_d   = row_left_q;
    top_row_d    = top_row_q;
    open_row_d   = open_row_q;
    row_open_d   = row_open_q;
    cmd_d        = cmd_q;
    y_d          = y_q;
    cov_d        = cov_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    ptr_d        = ptr_q;
    cur_len_d    = cur_len_q;
    cur_alpha_d  = cur_alpha_q;
    cur_start_d  = cur_start_q;
    pend_vld_d   = pend_vld_q;
    pend_len_d   = pend_len_q;
    pend_alpha_d = pend_alpha_q;
    pend_start_d = pend_start_q;
    out_vld_d    = out_vld_q;
    span_x_d     = span_x_q;
    span_y_d     = span_y_q;
    span_len_d   = span_len_q;
    span_alpha_d = span_alpha_q;
    last_d       = last_q;
    buf_req      = '0;
    stall        = 1'b0;
    finish       = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;

    // drop the span once the consumer takes it
    if (span_ready_i) begin
      out_vld_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        rcsa_pkg::CFG_ROW_LEFT: row_left_d = cfg_wdata_i;
        rcsa_pkg::CFG_TOP_ROW:  top_row_d  = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = command_i;
          y_d        = pixel_y_i;
          cov_d      = coverage_i;
          rem_d      = run_len_i;
          idx_d      = {{2{pixel_x_i[rcsa_pkg::COORD_W-1]}}, pixel_x_i}
                     - {{2{row_left_q[rcsa_pkg::COORD_W-1]}}, row_left_q};
          ptr_d      = '0;
          cur_len_d  = '0;
          pend_vld_d = 1'b0;
          if (command_i == rcsa_pkg::CMD_FLUSH) begin
            if (row_open_q) begin
              // start the scan: read cell 0 now, evaluate it next cycle
              buf_req.rd_en = 1'b1;
              state_d       = ST_SCAN_EV;
            end
          end else if (pixel_y_i >= top_row_q) begin
            if (!row_open_q) begin
              row_open_d = 1'b1;
              open_row_d = pixel_y_i;
              state_d    = ST_ACC_RD;
            end else if (open_row_q != pixel_y_i) begin
              buf_req.rd_en = 1'b1;
              state_d       = ST_SCAN_EV;
            end else begin
              state_d = ST_ACC_RD;
            end
          end
        end
      end

      ST_ACC_RD: begin
        if (rem_q == '0) begin
          state_d = ST_IDLE;
        end else if (in_range) begin
          buf_req.rd_en   = 1'b1;
          buf_req.rd_addr = idx_q[rcsa_pkg::ADDR_W-1:0];
          state_d         = ST_ACC_WR;
        end else begin
          // pixel outside the buffer: skip it
          idx_d = idx_q + rcsa_pkg::IDX_W'(1);
          rem_d = rem_q - rcsa_pkg::LEN_W'(1);
        end
      end

      ST_ACC_WR: begin
        buf_req.wr_en   = 1'b1;
        buf_req.wr_addr = idx_q[rcsa_pkg::ADDR_W-1:0];
        buf_req.wr_data = alu_res;
        idx_d           = idx_q + rcsa_pkg::IDX_W'(1);
        rem_d           = rem_q - rcsa_pkg::LEN_W'(1);
        state_d         = ST_ACC_RD;
      end

      ST_SCAN_EV: begin
        // a closing span bumps the waiting one out; hold if the output slot is busy
        stall = closing && pend_vld_q && !out_free;
        if (!stall) begin
          push = closing && pend_vld_q;
          if (closing) begin
            pend_vld_d   = 1'b1;
            pend_len_d   = cur_len_q;
            pend_alpha_d = cur_alpha_q;
            pend_start_d = cur_start_q;
          end
          if (extend) begin
            cur_len_d = cur_len_q + rcsa_pkg::LEN_W'(1);
          end else if (rd_data != '0) begin
            cur_len_d   = rcsa_pkg::LEN_W'(1);
            cur_alpha_d = rd_data;
            cur_start_d = ptr_q;
          end else begin
            cur_len_d = '0;
          end
          if (ptr_q == rcsa_pkg::ADDR_W'(rcsa_pkg::ROW_WIDTH - 1)) begin
            state_d = ST_SCAN_END;
          end else begin
            // advance: read the next cell while this one is evaluated
            buf_req.rd_en   = 1'b1;
            buf_req.rd_addr = ptr_q + rcsa_pkg::ADDR_W'(1);
            ptr_d           = ptr_q + rcsa_pkg::ADDR_W'(1);
          end
        end
      end

      ST_SCAN_END: begin
        if (cur_len_q != '0) begin
          stall = pend_vld_q && !out_free;
          if (!stall) begin
            push         = pend_vld_q;
            pend_vld_d   = 1'b1;
            pend_len_d   = cur_len_q;
            pend_alpha_d = cur_alpha_q;
            pend_start_d = cur_start_q;
            cur_len_d    = '0;
            state_d      = ST_SCAN_LAST;
          end
        end else begin
          state_d = ST_SCAN_LAST;
        end
      end

      ST_SCAN_LAST: begin
        if (pend_vld_q) begin
          stall = !out_free;
          if (!stall) begin
            push       = 1'b1;
            push_last  = 1'b1;
            pend_vld_d = 1'b0;
            finish     = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (push) begin
      out_vld_d    = 1'b1;
      span_x_d     = row_left_q + rcsa_pkg::COORD_W'(pend_start_q);
      span_y_d     = open_row_q;
      span_len_d   = pend_len_q;
      span_alpha_d = pend_alpha_q;
      last_d       = push_last;
    end

    if (finish) begin
      buf_req.clr = 1'b1;
      if (cmd_q == rcsa_pkg::CMD_FLUSH) begin
        row_open_d = 1'b0;
        state_d    = ST_IDLE;
      end else begin
        open_row_d = y_q;
        state_d    = ST_ACC_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_left_q   <= '0;
      top_row_q    <= '0;
      open_row_q   <= '0;
      row_open_q   <= 1'b0;
      cmd_q        <= rcsa_pkg::CMD_ACC;
      y_q          <= '0;
      cov_q        <= '0;
      rem_q        <= '0;
      idx_q        <= '0;
      ptr_q        <= '0;
      cur_len_q    <= '0;
      cur_alpha_q  <= '0;
      cur_start_q  <= '0;
      pend_vld_q   <= 1'b0;
      pend_len_q   <= '0;
      pend_alpha_q <= '0;
      pend_start_q <= '0;
      out_vld_q    <= 1'b0;
      span_x_q     <= '0;
      span_y_q     <= '0;
      span_len_q   <= '0;
      span_alpha_q <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_left_q   <= row_left_d;
      top_row_q    <= top_row_d;
      open_row_q   <= open_row_d;
      row_open_q   <= row_open_d;
      cmd_q        <= cmd_d;
      y_q          <= y_d;
      cov_q        <= cov_d;
      rem_q        <= rem_d;
      idx_q        <= idx_d;
      ptr_q        <= ptr_d;
      cur_len_q    <= cur_len_d;
      cur_alpha_q  <= cur_alpha_d;
      cur_start_q  <= cur_start_d;
      pend_vld_q   <= pend_vld_d;
      pend_len_q   <= pend_len_d;
      pend_alpha_q <= pend_alpha_d;
      pend_start_q <= pend_start_d;
      out_vld_q    <= out_vld_d;
      span_x_q     <= span_x_d;
      span_y_q     <= span_y_d;
      span_len_q   <= span_len_d;
      span_alpha_q <= span_alpha_d;
      last_q       <= last_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign span_valid_o = out_vld_q;
  assign span_x_o     = span_x_q;
  assign span_y_o     = span_y_q;
  assign span_len_o   = span_len_q;
  assign span_alpha_o = span_alpha_q;
  assign last_o       = last_q;

`ifndef ASSERT_OFF
  // a span on offer always carries coverage and length
  a_span_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (span_alpha_q != '0) && (span_len_q != '0))
    else $error("span with zero coverage or zero length");

  // an idle sequencer holds no partial or waiting span
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_vld_q && (cur_len_q == '0))
    else $error("idle with a span left over from the scan");

  // the write-back uses data read in the previous cycle
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC_WR) |-> $past(buf_req.rd_en))
    else $error("accumulate write without a preceding read");

  // closing a scan hands out the waiting span
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_LAST && out_free) |=> !pend_vld_q)
    else $error("waiting span not delivered at end of scan");
`endif

endmodule

// ===== rtl/rcsa_alu.sv =====
// Shared 8-bit unit: saturating add for accumulation, equality compare for span scan.
module rcsa_alu (
  input  rcsa_pkg::alu_op_e                op_i,
  input  logic [rcsa_pkg::ALPHA_W-1:0]     a_i,
  input  logic [rcsa_pkg::ALPHA_W-1:0]     b_i,
  output logic [rcsa_pkg::ALPHA_W-1:0]     res_o,
  output logic                             eq_o
);

  logic [rcsa_pkg::ALPHA_W-1:0] b_op;
  logic [rcsa_pkg::ALPHA_W:0]   sum;
  logic                         cin;

  always_comb begin
    cin  = (op_i == rcsa_pkg::ALU_CMP);
    b_op = cin ? ~b_i : b_i;
    sum  = {1'b0, a_i} + {1'b0, b_op} + {{rcsa_pkg::ALPHA_W{1'b0}}, cin};
    case (op_i)
      rcsa_pkg::ALU_ADD_SAT: begin
        res_o = sum[rcsa_pkg::ALPHA_W] ? rcsa_pkg::ALPHA_MAX : sum[rcsa_pkg::ALPHA_W-1:0];
      end
      default: begin
        res_o = sum[rcsa_pkg::ALPHA_W-1:0];
      end
    endcase
    eq_o = (sum[rcsa_pkg::ALPHA_W-1:0] == '0);
  end

endmodule

// ===== rtl/rcsa_row_buf.sv =====
// Row coverage memory: one write and one registered read port.
// Per-entry valid bits make unwritten cells read as zero; clr empties the row at once.
module rcsa_row_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rcsa_pkg::buf_req_t           req_i,
  output logic [rcsa_pkg::ALPHA_W-1:0] rd_data_o
);

  logic [rcsa_pkg::ALPHA_W-1:0] mem [rcsa_pkg::ROW_WIDTH];
  logic [rcsa_pkg::ROW_WIDTH-1:0] valid_q;
  logic [rcsa_pkg::ALPHA_W-1:0] rd_mem_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_mem_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_mem_q : '0;

endmodule

// ===== verif/row_coverage_span_accumulator_core_tb.sv =====
module row_coverage_span_accumulator_core_tb;
  import rcsa_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  // An accumulate item with no row change can keep the block busy without
  // producing a span; SETTLE_CYCLES leaves room for the longest such item.
  localparam int SETTLE_CYCLES = 256;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int HOLD_CYCLES   = 400;

  // One input transfer as the sender sees it.
  typedef struct {
    logic                      cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LEN_W-1:0]          len;
    logic [ALPHA_W-1:0]        cov;
  } item_t;

  // One span as it leaves the block.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LEN_W-1:0]          len;
    logic [ALPHA_W-1:0]        alpha;
    logic                      last;
  } span_t;

  // Keeps a private copy of the row buffer and registers, turns every
  // accepted input into the spans it must cause, and checks arriving spans
  // against them in order.
  class span_predictor;
    logic [ALPHA_W-1:0]        cells[ROW_WIDTH];
    logic [COORD_W-1:0]        cur_row;
    bit                        row_live;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    span_t                     pending_spans[$];
    int                        errors;
    int                        spans_seen;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cur_row    = '0;
      row_live   = 1'b0;
      left       = '0;
      top        = '0;
      errors     = 0;
      spans_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      if (idx == CFG_ROW_LEFT) left = val;
      else if (idx == CFG_TOP_ROW) top = val;
    endfunction

    function int pending();
      return pending_spans.size();
    endfunction

    // Scan the open row into spans of equal non-zero coverage, then clear it.
    // With a 64-cell row no emission can exceed 64 spans or 64 pixels per span.
    function void close_row();
      int         pos;
      int         start;
      int         first;
      span_t      s;
      first = pending_spans.size();
      pos   = 0;
      while (pos < ROW_WIDTH) begin
        if (cells[pos] != '0) begin
          start = pos;
          pos++;
          while (pos < ROW_WIDTH && cells[pos] == cells[start] &&
                 pos - start < SPAN_MAX_LEN)
            pos++;
          s.x     = left + COORD_W'(start);
          s.y     = cur_row;
          s.len   = LEN_W'(pos - start);
          s.alpha = cells[start];
          s.last  = 1'b0;
          pending_spans = {pending_spans, s};
        end else begin
          pos++;
        end
      end
      if (pending_spans.size() > first)
        pending_spans[pending_spans.size() - 1].last = 1'b1;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void accept_item(item_t it);
      int base;
      int idx;
      int sum;
      if (it.cmd == CMD_FLUSH) begin
        if (row_live) begin
          close_row();
          row_live = 1'b0;
        end
        return;
      end
      // rows above the top row are dropped without touching the open row
      if (it.y < top) return;
      if (!row_live) begin
        row_live = 1'b1;
      end else if (cur_row != it.y) begin
        close_row();
      end
      cur_row = it.y;
      base = int'(it.x) - int'(left);
      for (int i = 0; i < int'(it.len); i++) begin
        idx = base + i;
        if (idx >= 0 && idx < ROW_WIDTH) begin
          sum = int'(cells[idx]) + int'(it.cov);
          cells[idx] = (sum > int'(ALPHA_MAX)) ? ALPHA_MAX : ALPHA_W'(sum);
        end
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_span(span_t got);
      span_t want;
      spans_seen++;
      if (pending_spans.size() == 0) begin
        $error("span with nothing expected: x %0d, y %0d, len %0d, alpha %0d",
               got.x, got.y, got.len, got.alpha);
        errors++;
        return;
      end
      want = pending_spans.pop_front();
      compare_field("span_x", int'(want.x), int'(got.x));
      compare_field("span_y", int'(want.y), int'(got.y));
      compare_field("span_len", int'(want.len), int'(got.len));
      compare_field("span_alpha", int'(want.alpha), int'(got.alpha));
      compare_field("last", int'(want.last), int'(got.last));
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [COORD_W-1:0]        cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      command_i;
  logic signed [COORD_W-1:0] pixel_x_i;
  logic signed [COORD_W-1:0] pixel_y_i;
  logic [LEN_W-1:0]          run_len_i;
  logic [ALPHA_W-1:0]        coverage_i;
  logic                      span_valid_o;
  logic                      span_ready_i;
  logic signed [COORD_W-1:0] span_x_o;
  logic signed [COORD_W-1:0] span_y_o;
  logic [LEN_W-1:0]          span_len_o;
  logic [ALPHA_W-1:0]        span_alpha_o;
  logic                      last_o;

  row_coverage_span_accumulator_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .run_len_i    (run_len_i),
    .coverage_i   (coverage_i),
    .span_valid_o (span_valid_o),
    .span_ready_i (span_ready_i),
    .span_x_o     (span_x_o),
    .span_y_o     (span_y_o),
    .span_len_o   (span_len_o),
    .span_alpha_o (span_alpha_o),
    .last_o       (last_o)
  );

  span_predictor pred;

  // Traffic shaping, changed by the main sequence from phase to phase.
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;

  // Register values currently programmed and the row the random items favor.
  logic signed [COORD_W-1:0] row_left_cfg;
  logic signed [COORD_W-1:0] top_cfg;
  int                        cur_y;
  int                        items_sent;
  int                        settings_used;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Hard stop in case the block hangs on either channel.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  // Span receiver: check every span transfer, then pick the next ready.
  // A pending hold request forces ready low until hold_cycles runs out.
  initial begin
    span_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (span_valid_o && span_ready_i)
        pred.check_span(span_t'{span_x_o, span_y_o, span_len_o, span_alpha_o, last_o});
      if (hold_cycles > 0) begin
        span_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        span_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic item_t make_acc(int x, int y, int len, int cov);
    item_t it;
    it.cmd = CMD_ACC;
    it.x   = COORD_W'(x);
    it.y   = COORD_W'(y);
    it.len = LEN_W'(len);
    it.cov = ALPHA_W'(cov);
    return it;
  endfunction

  // Flush with random payload; the block must ignore every field but the command.
  function automatic item_t make_flush();
    item_t it;
    it.cmd = CMD_FLUSH;
    it.x   = COORD_W'($urandom_range(0, 65535));
    it.y   = COORD_W'($urandom_range(0, 65535));
    it.len = LEN_W'($urandom_range(0, 127));
    it.cov = ALPHA_W'($urandom_range(0, 255));
    return it;
  endfunction

  // Mostly runs on a few rows at or just below the top row and near the
  // buffer window, so rows fill up and change; some noise everywhere else.
  function automatic item_t rand_item();
    int r;
    int yv;
    int xv;
    int lv;
    int cv;
    if ($urandom_range(99) < 8) return make_flush();
    r = $urandom_range(99);
    if (r < 12) begin
      cur_y = clamp16(int'(top_cfg) + int'($urandom_range(0, 3)));
      yv = cur_y;
    end else if (r < 17) begin
      yv = int'(top_cfg) - int'($urandom_range(1, 4));
    end else if (r < 21) begin
      yv = int'($urandom_range(0, 65535));
    end else begin
      yv = cur_y;
    end
    if ($urandom_range(99) < 10) xv = int'($urandom_range(0, 65535));
    else xv = int'(row_left_cfg) + int'($urandom_range(0, 88)) - 16;
    r = $urandom_range(99);
    if (r < 70) lv = $urandom_range(1, 16);
    else if (r < 90) lv = $urandom_range(17, 64);
    else lv = $urandom_range(0, 127);
    r = $urandom_range(99);
    if (r < 5) cv = 0;
    else if (r < 25) cv = 255;
    else if (r < 55) cv = $urandom_range(1, 8);
    else cv = $urandom_range(0, 255);
    return make_acc(xv, yv, lv, cv);
  endfunction

  // Offer one item after an optional random gap and hold it until the transfer.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= it.cmd;
    pixel_x_i  <= it.x;
    pixel_y_i  <= it.y;
    run_len_i  <= it.len;
    coverage_i <= it.cov;
    do @(posedge clk_i); while (!in_ready_o);
    pred.accept_item(it);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted span has been received.
  task automatic wait_spans_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pred.pending() > 0) @(posedge clk_i);
  endtask

  // Drain, then let any silent accumulate finish so the block is idle.
  task automatic drain_and_settle();
    wait_spans_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Program both registers back to back; call only while the block is idle.
  task automatic set_window(input int left, input int top);
    row_left_cfg = COORD_W'(left);
    top_cfg      = COORD_W'(top);
    cur_y        = int'(top_cfg);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROW_LEFT;
    cfg_wdata_i <= row_left_cfg;
    @(posedge clk_i);
    pred.write_reg(CFG_ROW_LEFT, row_left_cfg);
    cfg_idx_i   <= CFG_TOP_ROW;
    cfg_wdata_i <= top_cfg;
    @(posedge clk_i);
    pred.write_reg(CFG_TOP_ROW, top_cfg);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  task automatic random_items(input int count);
    repeat (count) send_item(rand_item());
  endtask

  initial begin
    pred          = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ROW_LEFT;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_ACC;
    pixel_x_i     = '0;
    pixel_y_i     = '0;
    run_len_i     = '0;
    coverage_i    = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    row_left_cfg  = '0;
    top_cfg       = '0;
    cur_y         = 0;
    items_sent    = 0;
    settings_used = 1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass on reset register values, no idling on either side.
    send_item(make_flush());                  // flush with no row open
    send_item(make_acc(0, -1, 4, 9));         // row above top: dropped
    send_item(make_acc(0, -32768, 127, 255)); // lowest row: dropped
    send_item(make_acc(0, 0, 0, 50));         // first row opens on zero length
    send_item(make_acc(0, 0, 64, 0));         // zero coverage adds nothing
    send_item(make_flush());                  // empty row: no spans
    send_item(make_acc(-32768, 3, 127, 255)); // entirely left of the buffer
    send_item(make_acc(32767, 3, 1, 255));    // entirely right of the buffer
    send_item(make_acc(-5, 3, 127, 200));     // overhangs both ends
    send_item(make_acc(10, 3, 10, 100));      // saturates at the maximum
    send_item(make_acc(62, 3, 64, 1));
    send_item(make_acc(0, 32767, 1, 1));      // row change emits row 3
    send_item(make_acc(63, 32767, 1, 255));
    send_item(make_acc(5, -32768, 3, 3));     // above top, row stays open
    send_item(make_flush());
    send_item(make_flush());                  // nothing open any more
    send_item(make_acc(0, 1, 64, 128));
    send_item(make_acc(0, 1, 64, 127));
    send_item(make_acc(0, 1, 64, 1));         // already saturated
    send_item(make_acc(1, 2, 126, 1));        // one full-width span out
    send_item(make_flush());
    drain_and_settle();

    // Lowest register values, full throughput.
    set_window(-32768, -32768);
    random_items(40);
    drain_and_settle();

    // Window near the top of the coordinate range so span_x wraps; sender gaps.
    set_window(32760, -5);
    send_idle_pct = 64;
    send_item(make_acc(32767, 0, 40, 77));
    random_items(40);
    drain_and_settle();

    // Highest register values: only the last row passes; receiver stalls.
    set_window(32767, 32767);
    send_idle_pct = 0;
    stall_pct     = 64;
    random_items(25);
    drain_and_settle();

    // Light idling on both sides with back pressure and a full span burst.
    set_window(-40, 100);
    send_idle_pct = 9;
    stall_pct     = 9;
    // Hold the receiver off while alternating rows keep forcing emissions,
    // so the block backs up and stalls its input.
    hold_cycles = HOLD_CYCLES;
    for (int k = 0; k < 8; k++)
      send_item(make_acc(-40 + 3 * k, 100 + (k % 2), 5, $urandom_range(1, 255)));
    // Pause the sender until every span has come out.
    wait_spans_done();
    // Alternate 1 and 2 across the whole row: the longest emission possible.
    send_item(make_acc(-40, 102, 64, 1));
    for (int k = 0; k < 32; k++)
      send_item(make_acc(-40 + 2 * k + 1, 102, 1, 1));
    send_item(make_flush());
    random_items(20);
    drain_and_settle();

    // Random window, heavy idling on both sides.
    set_window($urandom_range(0, 65535), $urandom_range(0, 65535));
    send_idle_pct = 64;
    stall_pct     = 64;
    random_items(25);
    send_item(make_flush());
    drain_and_settle();

    $display("covered %0d input transfers and %0d spans across %0d register settings",
             items_sent, pred.spans_seen, settings_used);
    $display("including dropped rows, buffer overhang, saturation, wrap and a full-row burst");
    if (pred.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
